/* sv/swar_pkg.sv */
package swar_pkg;

  localparam int FIELD_W    = 12;
  localparam int VAL_W      = 13;
  localparam int SUM_W      = 32;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int SHIFT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int DEF_WINDOW_DEPTH = 256;
  localparam int DEF_SAMPLE_BITS  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIAS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WLOG2 = CFG_IDX_W'(2);

  localparam logic [SHIFT_W-1:0] WLOG2_RESET = SHIFT_W'(1);

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_DC   = 2'd1,
    MODE_AC   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MEAN,
    ST_SQ_NEW,
    ST_ACCUM,
    ST_ROOT,
    ST_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic rd;
    logic wr;
  } ring_ctl_t;

  // largest s with 2^s <= v, at least 1
  function automatic int floor_log2(input int v);
    int s;
    s = 0;
    while (s < 30 && (2 << s) <= v) s++;
    if (s < 1) s = 1;
    return s;
  endfunction

endpackage

/* sv/swar_if.sv */
interface swar_in_if;
  import swar_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swar_out_if;
  import swar_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] instant_value;
  logic [FIELD_W-1:0] window_mean;
  logic [FIELD_W-1:0] window_rms;

  modport source (output valid, output instant_value, output window_mean,
                  output window_rms, input ready);
  modport sink   (input valid, input instant_value, input window_mean,
                  input window_rms, output ready);
endinterface

interface swar_cfg_if;
  import swar_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/sliding_window_average_and_rms.sv */
// Path from input word to result word: mode none loads the output directly; DC mode
// does ring read, sum update and mean update; AC mode does ring read, two squares,
// sum update, the square root unit that yields one root bit a cycle, then the hold
// update and output load. One word in flight: the next word is taken once the
// previous result sits in the output register.
// Reset (rst_n, synchronous) and any register write clear the window, the sum and
// the held mean and rms at once; no clearing pass is needed.
module sliding_window_average_and_rms #(
  parameter int WINDOW_DEPTH = swar_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = swar_pkg::DEF_SAMPLE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  swar_in_if.sink           in_ch,
  swar_out_if.source        out_ch,
  swar_cfg_if.sink          cfg_ch
);
  import swar_pkg::*;

  localparam int LIMIT = floor_log2(WINDOW_DEPTH);
  localparam logic [FIELD_W-1:0] SAMPLE_MASK = FIELD_W'((1 << SAMPLE_BITS) - 1);

  state_t state_r, state_nxt;

  logic [1:0]          mode_r;
  logic [FIELD_W-1:0]  bias_r;
  logic [SHIFT_W-1:0]  wlog2_r;
  logic [SHIFT_W-1:0]  shift;
  logic                cfg_hit;
  logic                cfg_clear;

  logic [FIELD_W-1:0]      smp_r;
  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;
  logic signed [VAL_W-1:0] old_value;
  logic signed [VAL_W-1:0] mul_a;
  logic signed [2*VAL_W-1:0] mul_p;
  logic [SUM_W-1:0]        sq_r;
  logic [SUM_W-1:0]        sum_r;
  logic [SUM_W-1:0]        sum_sh;
  logic [FIELD_W-1:0]      held_mean_r;
  logic [FIELD_W-1:0]      held_rms_r;

  logic                    accept;
  logic                    out_free;
  logic                    out_load;
  logic                    sqrt_start;
  logic                    sqrt_done;
  logic [ROOT_W-1:0]       sqrt_root;
  ring_ctl_t               ring_ctl;

  logic                    out_valid_r;
  logic [FIELD_W-1:0]      out_inst_r;
  logic [FIELD_W-1:0]      out_mean_r;
  logic [FIELD_W-1:0]      out_rms_r;

  // configuration
  assign cfg_ch.ready = 1'b1;
  assign cfg_hit      = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_hit) begin
      unique case (cfg_ch.index) inside
        REG_MODE, REG_BIAS, REG_WLOG2: cfg_clear = 1'b1;
        default:                       cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NONE;
      bias_r  <= '0;
      wlog2_r <= WLOG2_RESET;
    end else if (cfg_hit) begin
      unique case (cfg_ch.index)
        REG_MODE:  mode_r  <= cfg_ch.data[1:0];
        REG_BIAS:  bias_r  <= cfg_ch.data[FIELD_W-1:0];
        REG_WLOG2: wlog2_r <= cfg_ch.data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp window size into what the ring holds
  always_comb begin
    if (wlog2_r == '0) begin
      shift = SHIFT_W'(1);
    end else if (int'(wlog2_r) > LIMIT) begin
      shift = SHIFT_W'(LIMIT);
    end else begin
      shift = wlog2_r;
    end
  end

  // handshakes
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (mode_r == MODE_DC || mode_r == MODE_AC) state_nxt = ST_READ;
          else state_nxt = ST_FINISH;
        end
      end
      ST_READ:   state_nxt = (mode_r == MODE_DC) ? ST_MEAN : ST_SQ_NEW;
      ST_MEAN:   state_nxt = ST_FINISH;
      ST_SQ_NEW: state_nxt = ST_ACCUM;
      ST_ACCUM:  state_nxt = ST_ROOT;
      ST_ROOT:   state_nxt = ST_WAIT;
      ST_WAIT:   if (sqrt_done) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready    = 1'b0;
    ring_ctl.clear = cfg_clear;
    ring_ctl.rd    = 1'b0;
    ring_ctl.wr    = 1'b0;
    sqrt_start     = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ring_ctl.rd = in_ch.valid;
      end
      ST_READ:   ring_ctl.wr = 1'b1;
      ST_ROOT:   sqrt_start  = 1'b1;
      ST_FINISH: out_load    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sample capture
  always_comb begin
    if (mode_r == MODE_AC) begin
      val_nxt = VAL_W'(in_ch.sample & SAMPLE_MASK) - VAL_W'(bias_r);
    end else begin
      val_nxt = VAL_W'(in_ch.sample & SAMPLE_MASK);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r <= in_ch.sample & SAMPLE_MASK;
      val_r <= val_nxt;
    end
  end

  // one squarer: old value while reading, new value the cycle after
  assign mul_a = (state_r == ST_READ) ? old_value : val_r;
  assign mul_p = mul_a * mul_a;

  always_ff @(posedge clk) begin
    if (state_r == ST_READ || state_r == ST_SQ_NEW) begin
      sq_r <= SUM_W'(unsigned'(mul_p));
    end
  end

  assign sum_sh = sum_r >> shift;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      sum_r       <= '0;
      held_mean_r <= '0;
      held_rms_r  <= '0;
    end else begin
      case (state_r)
        ST_READ: begin
          if (mode_r == MODE_DC) begin
            sum_r <= sum_r - SUM_W'(old_value) + SUM_W'(smp_r);
          end
        end
        ST_SQ_NEW: sum_r       <= sum_r - sq_r;
        ST_ACCUM:  sum_r       <= sum_r + sq_r;
        ST_MEAN:   held_mean_r <= sum_sh[FIELD_W-1:0];
        ST_WAIT: begin
          if (sqrt_done) held_rms_r <= sqrt_root[FIELD_W-1:0];
        end
        default: ;
      endcase
    end
  end

  swar_ring #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ring_ctl),
    .shift     (shift),
    .wdata     (val_r),
    .old_value (old_value)
  );

  swar_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     (sum_sh),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_inst_r <= smp_r;
      out_mean_r <= held_mean_r;
      out_rms_r  <= held_rms_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.instant_value = out_inst_r;
  assign out_ch.window_mean   = out_mean_r;
  assign out_ch.window_rms    = out_rms_r;

endmodule

/* sv/swar_ring.sv */
module swar_ring #(
  parameter int WINDOW_DEPTH = swar_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  swar_pkg::ring_ctl_t                  ctl,
  input  logic [swar_pkg::SHIFT_W-1:0]         shift,
  input  logic signed [swar_pkg::VAL_W-1:0]    wdata,
  output logic signed [swar_pkg::VAL_W-1:0]    old_value
);
  import swar_pkg::*;

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);

  logic signed [VAL_W-1:0] mem [WINDOW_DEPTH];
  logic signed [VAL_W-1:0] rdata_r;
  logic [ADDR_W-1:0]       pos_r;
  logic [ADDR_W-1:0]       pos_nxt;
  logic                    wrapped_r;
  logic                    wrapped_nxt;
  logic [ADDR_W:0]         len;
  logic                    last;

  assign len  = (ADDR_W+1)'(1) << shift;
  assign last = ({1'b0, pos_r} + (ADDR_W+1)'(1)) == len;

  // entries at or past the write position are unwritten until the first wrap
  assign old_value = wrapped_r ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[pos_r] <= wdata;
    end
    if (ctl.rd) begin
      rdata_r <= mem[pos_r];
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    wrapped_nxt = wrapped_r;
    if (ctl.clear) begin
      pos_nxt     = '0;
      wrapped_nxt = 1'b0;
    end else if (ctl.wr) begin
      if (last) begin
        pos_nxt     = '0;
        wrapped_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      wrapped_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

endmodule

/* sv/swar_sqrt.sv */
module swar_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [swar_pkg::SUM_W-1:0]    x,
  output logic                          done,
  output logic [swar_pkg::ROOT_W-1:0]   root
);
  import swar_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;

  logic [SUM_W-1:0]  x_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              fits;

  // one result bit per cycle: bring down two bits, try root*4+1
  assign rem_sh = {rem_r, x_r[SUM_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= x_r << 2;
      rem_r  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
